// ===== hdl/macd_pkg.sv =====
// ----------------------------------------------------------------------------
// macd_pkg
// Widths, register indices and reset weights shared by the MACD oscillator
// and its checker.
// ----------------------------------------------------------------------------
package macd_pkg;

	localparam int PRICE_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int ALPHA_BITS = 16;

	// averages and differences, all with FRAC_BITS fraction bits
	localparam int AVG_W   = PRICE_BITS + FRAC_BITS;
	localparam int DIFFQ_W = AVG_W + 1;
	localparam int SIG_W   = AVG_W + 2;
	localparam int D_W     = SIG_W + 1;

	// split of the difference across two passes of the multiplier
	localparam int LO_W   = (D_W + 1) / 2;
	localparam int HI_W   = D_W - LO_W;
	localparam int MUL_W  = LO_W + 1;
	localparam int PROD_W = MUL_W + ALPHA_BITS + 1;
	localparam int ACC_W  = D_W + ALPHA_BITS + 1;
	localparam int STEP_W = ACC_W - ALPHA_BITS;

	// result fields
	localparam int DIFF_LINE_W = PRICE_BITS + 1;
	localparam int HIST_W      = PRICE_BITS + 3;
	localparam int TIME_W      = 32;

	// configuration port
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_FAST_ALPHA   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SLOW_ALPHA   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SIGNAL_ALPHA = 2'd2;

	localparam logic [ALPHA_BITS-1:0] FAST_ALPHA_RST   = 16'd10082;
	localparam logic [ALPHA_BITS-1:0] SLOW_ALPHA_RST   = 16'd4855;
	localparam logic [ALPHA_BITS-1:0] SIGNAL_ALPHA_RST = 16'd13107;

endpackage

// ===== hdl/macd_ema_oscillator.sv =====
// ----------------------------------------------------------------------------
// macd_ema_oscillator
// MACD oscillator over closing prices: fast and slow EMAs, their difference,
// the signal EMA of that difference and the histogram bar.
// ----------------------------------------------------------------------------
// One price word is taken at a time. A series-start word loads both price
// averages, clears the signal average and then loads a zero result. Any
// other word runs the three EMA updates in turn through one shared 27 x 17
// bit multiplier, each by subtract, low partial product, high partial
// product, then round and add; the fast-slow difference is taken between
// the slow and signal updates, and the result register is loaded last. The
// input is ready again once the result register is loaded, so a waiting
// result does not hold off the next word. Alpha weights are Q0.16 and are
// to be written only while the block is idle; the block does not enforce it.
module macd_ema_oscillator (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     wr_en,
	input  logic [macd_pkg::REG_IDX_W-1:0]           wr_index,
	input  logic [macd_pkg::ALPHA_BITS-1:0]          wr_data,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [macd_pkg::PRICE_BITS-1:0]          close_price,
	input  logic [macd_pkg::TIME_W-1:0]              bar_time,
	input  logic                                     series_start,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [macd_pkg::DIFF_LINE_W-1:0]  diff_line,
	output logic signed [macd_pkg::DIFF_LINE_W-1:0]  dea_line,
	output logic signed [macd_pkg::HIST_W-1:0]       histogram_bar,
	output logic [macd_pkg::TIME_W-1:0]              result_time
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SUB    = 3'd1;
	localparam logic [2:0] ST_MUL_LO = 3'd2;
	localparam logic [2:0] ST_MUL_HI = 3'd3;
	localparam logic [2:0] ST_UPD    = 3'd4;
	localparam logic [2:0] ST_DIFF   = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	localparam logic [1:0] SEL_FAST = 2'd0;
	localparam logic [1:0] SEL_SLOW = 2'd1;
	localparam logic [1:0] SEL_SIG  = 2'd2;

	logic [2:0]                          state_q;
	logic [1:0]                          sel_q;
	logic [macd_pkg::ALPHA_BITS-1:0]     fast_alpha_q, slow_alpha_q, signal_alpha_q;
	logic [macd_pkg::AVG_W-1:0]          fast_q, slow_q, price_q;
	logic signed [macd_pkg::SIG_W-1:0]   sig_q;
	logic signed [macd_pkg::DIFFQ_W-1:0] diff_q;
	logic signed [macd_pkg::D_W-1:0]     d_q;
	logic signed [macd_pkg::ACC_W-1:0]   acc_q;
	logic [macd_pkg::TIME_W-1:0]         time_q;
	logic                                out_valid_q;

	logic signed [macd_pkg::D_W-1:0]     avg_ext, target_ext, gap;
	logic [macd_pkg::ALPHA_BITS-1:0]     alpha;
	logic signed [macd_pkg::MUL_W-1:0]   mul_a;
	logic signed [macd_pkg::PROD_W-1:0]  prod;
	logic signed [macd_pkg::ACC_W-1:0]   prod_ext, acc_rnd;
	logic signed [macd_pkg::STEP_W-1:0]  step, avg_new;
	logic                                in_acc, out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// operand selection for the shared unit
	always_comb begin
		case (sel_q)
			SEL_FAST: begin
				avg_ext    = {{(macd_pkg::D_W - macd_pkg::AVG_W){1'b0}}, fast_q};
				target_ext = {{(macd_pkg::D_W - macd_pkg::AVG_W){1'b0}}, price_q};
				alpha      = fast_alpha_q;
			end
			SEL_SLOW: begin
				avg_ext    = {{(macd_pkg::D_W - macd_pkg::AVG_W){1'b0}}, slow_q};
				target_ext = {{(macd_pkg::D_W - macd_pkg::AVG_W){1'b0}}, price_q};
				alpha      = slow_alpha_q;
			end
			default: begin
				avg_ext    = {{(macd_pkg::D_W - macd_pkg::SIG_W){sig_q[macd_pkg::SIG_W-1]}},
					sig_q};
				target_ext = {{(macd_pkg::D_W - macd_pkg::DIFFQ_W){diff_q[macd_pkg::DIFFQ_W-1]}},
					diff_q};
				alpha      = signal_alpha_q;
			end
		endcase
	end

	always_comb begin
		if (state_q == ST_MUL_HI) begin
			mul_a = {{(macd_pkg::MUL_W - macd_pkg::HI_W){d_q[macd_pkg::D_W-1]}},
				d_q[macd_pkg::D_W-1:macd_pkg::LO_W]};
		end else begin
			mul_a = {1'b0, d_q[macd_pkg::LO_W-1:0]};
		end
		prod     = mul_a * $signed({1'b0, alpha});
		prod_ext = {{(macd_pkg::ACC_W - macd_pkg::PROD_W){prod[macd_pkg::PROD_W-1]}}, prod};
		acc_rnd  = acc_q + macd_pkg::ACC_W'(1 << (macd_pkg::ALPHA_BITS - 1));
		step     = acc_rnd[macd_pkg::ACC_W-1:macd_pkg::ALPHA_BITS];
		avg_new  = {{(macd_pkg::STEP_W - macd_pkg::D_W){avg_ext[macd_pkg::D_W-1]}}, avg_ext}
			+ step;
		gap      = {{(macd_pkg::D_W - macd_pkg::DIFFQ_W){diff_q[macd_pkg::DIFFQ_W-1]}}, diff_q}
			- {{(macd_pkg::D_W - macd_pkg::SIG_W){sig_q[macd_pkg::SIG_W-1]}}, sig_q};
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_alpha_q   <= macd_pkg::FAST_ALPHA_RST;
			slow_alpha_q   <= macd_pkg::SLOW_ALPHA_RST;
			signal_alpha_q <= macd_pkg::SIGNAL_ALPHA_RST;
		end else if (wr_en) begin
			case (wr_index)
				macd_pkg::REG_FAST_ALPHA:   fast_alpha_q   <= wr_data;
				macd_pkg::REG_SLOW_ALPHA:   slow_alpha_q   <= wr_data;
				macd_pkg::REG_SIGNAL_ALPHA: signal_alpha_q <= wr_data;
				default: ;
			endcase
		end
	end

	// sequencer and average state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= SEL_FAST;
			out_valid_q <= 1'b0;
			fast_q      <= '0;
			slow_q      <= '0;
			sig_q       <= '0;
			diff_q      <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						sel_q <= SEL_FAST;
						if (series_start) begin
							fast_q  <= {close_price, {macd_pkg::FRAC_BITS{1'b0}}};
							slow_q  <= {close_price, {macd_pkg::FRAC_BITS{1'b0}}};
							sig_q   <= '0;
							diff_q  <= '0;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_SUB;
						end
					end
				end
				ST_SUB:    state_q <= ST_MUL_LO;
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_UPD;
				ST_UPD: begin
					case (sel_q)
						SEL_FAST: begin
							fast_q  <= avg_new[macd_pkg::AVG_W-1:0];
							sel_q   <= SEL_SLOW;
							state_q <= ST_SUB;
						end
						SEL_SLOW: begin
							slow_q  <= avg_new[macd_pkg::AVG_W-1:0];
							state_q <= ST_DIFF;
						end
						default: begin
							sig_q   <= avg_new[macd_pkg::SIG_W-1:0];
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_DIFF: begin
					diff_q  <= $signed({1'b0, fast_q}) - $signed({1'b0, slow_q});
					sel_q   <= SEL_SIG;
					state_q <= ST_SUB;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath words
	always_ff @(posedge clk) begin
		if (in_acc) begin
			price_q <= {close_price, {macd_pkg::FRAC_BITS{1'b0}}};
			time_q  <= bar_time;
		end
		if (state_q == ST_SUB) begin
			d_q <= target_ext - avg_ext;
		end
		if (state_q == ST_MUL_LO) begin
			acc_q <= prod_ext;
		end
		if (state_q == ST_MUL_HI) begin
			acc_q <= acc_q + (prod_ext <<< macd_pkg::LO_W);
		end
		if (out_load) begin
			diff_line     <= diff_q[macd_pkg::FRAC_BITS +: macd_pkg::DIFF_LINE_W];
			dea_line      <= sig_q[macd_pkg::FRAC_BITS +: macd_pkg::DIFF_LINE_W];
			histogram_bar <= gap[macd_pkg::FRAC_BITS-1 +: macd_pkg::HIST_W];
			result_time   <= time_q;
		end
	end

endmodule

// ===== hdl/macd_checker.sv =====
// ----------------------------------------------------------------------------
// macd_checker
// Port-level checks on the MACD oscillator, bound to the oscillator module.
// ----------------------------------------------------------------------------
module macd_checker (
	input logic                                     clk,
	input logic                                     arst_n,
	input logic                                     wr_en,
	input logic [macd_pkg::REG_IDX_W-1:0]           wr_index,
	input logic [macd_pkg::ALPHA_BITS-1:0]          wr_data,
	input logic                                     in_valid,
	input logic                                     in_ready,
	input logic [macd_pkg::PRICE_BITS-1:0]          close_price,
	input logic [macd_pkg::TIME_W-1:0]              bar_time,
	input logic                                     series_start,
	input logic                                     out_valid,
	input logic                                     out_ready,
	input logic signed [macd_pkg::DIFF_LINE_W-1:0]  diff_line,
	input logic signed [macd_pkg::DIFF_LINE_W-1:0]  dea_line,
	input logic signed [macd_pkg::HIST_W-1:0]       histogram_bar,
	input logic [macd_pkg::TIME_W-1:0]              result_time
);

	// a stalled result word stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// a stalled result word keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(diff_line) && $stable(dea_line)
			&& $stable(histogram_bar) && $stable(result_time))
		else $error("result word changed while stalled");

	// an accepted word keeps the block busy for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready straight after acceptance");

	// a new result only appears at the end of a busy period
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result word without preceding work");

endmodule

bind macd_ema_oscillator macd_checker u_macd_checker (.*);
